// ===== rtl/core/rbf_pkg.sv =====
// Shared constants, types and tap arithmetic for the 3x3 RGB blur filter.
// Depends on nothing; every other file of the block but rbf_ram imports it.
package rbf_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int EW_W       = COL_W + 1;
	localparam int MAX_HEIGHT = 4096;
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int EH_W       = ROW_W + 1;
	localparam int CFG_W      = 13;
	localparam int IDX_W      = 2;
	localparam int CH_W       = 8;
	localparam int PIX_W      = 3 * CH_W;
	localparam int COORD_W    = 12;
	localparam int RST_WIDTH  = 640;
	localparam int RST_HEIGHT = 480;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	// floor(k*s/167) is computed as (s * k * RECIP) >> RECIP_SH, exact for k*s below 61680.
	localparam int RECIP    = 6279;
	localparam int RECIP_SH = 20;
	localparam int KMUL_CORNER = 17 * RECIP;
	localparam int KMUL_EDGE   = 19 * RECIP;
	localparam int KMUL_CENTER = 23 * RECIP;
	localparam int KMUL_W   = 18;
	localparam int PROD_W   = CH_W + KMUL_W;
	localparam int TAP_W    = 6;
	localparam int SUM_W    = TAP_W + 4;

	typedef enum logic [IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1
	} reg_idx_t;

	typedef logic [PIX_W-1:0] pixel_t;
	typedef logic [2:0][2:0][PIX_W-1:0] window_t;

	// One queue entry: the window seen when an item arrived and which results it releases.
	typedef struct packed {
		window_t          win;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [3:0]       mask;
	} job_t;

	function automatic logic [KMUL_W-1:0] kmul_at(input int i, input int j);
		logic [KMUL_W-1:0] k;
		if (i == 1 && j == 1) begin
			k = KMUL_W'(KMUL_CENTER);
		end else if (i == 1 || j == 1) begin
			k = KMUL_W'(KMUL_EDGE);
		end else begin
			k = KMUL_W'(KMUL_CORNER);
		end
		return k;
	endfunction

	function automatic logic [TAP_W-1:0] tap_div(input logic [CH_W-1:0] s,
		input logic [KMUL_W-1:0] k);
		logic [PROD_W-1:0] p;
		p = PROD_W'(s) * PROD_W'(k);
		return TAP_W'(p >> RECIP_SH);
	endfunction

endpackage

// ===== rtl/core/rbf_pix_in_if.sv =====
// Input pixel channel of the blur filter: valid/ready plus one RGB888 pixel.
// Depends on rbf_pkg.
interface rbf_pix_in_if
	import rbf_pkg::*;
();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] in_red;
	logic [CH_W-1:0] in_green;
	logic [CH_W-1:0] in_blue;

	modport source(output valid, in_red, in_green, in_blue, input ready);
	modport sink(input valid, in_red, in_green, in_blue, output ready);
endinterface

// ===== rtl/core/rbf_pix_out_if.sv =====
// Output channel of the blur filter: filtered pixel with its coordinates.
// Depends on rbf_pkg.
interface rbf_pix_out_if
	import rbf_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [CH_W-1:0]    out_red;
	logic [CH_W-1:0]    out_green;
	logic [CH_W-1:0]    out_blue;
	logic [COORD_W-1:0] out_col;
	logic [COORD_W-1:0] out_row;
	logic               frame_done;

	modport source(output valid, out_red, out_green, out_blue, out_col, out_row, frame_done,
		input ready);
	modport sink(input valid, out_red, out_green, out_blue, out_col, out_row, frame_done,
		output ready);
endinterface

// ===== rtl/core/rbf_cfg_if.sv =====
// Configuration write channel of the blur filter: register index and data.
// Depends on rbf_pkg.
interface rbf_cfg_if
	import rbf_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] index;
	logic [CFG_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/rbf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing.
module rbf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/core/rbf_front.sv =====
// Front end: accepts pixels, tracks the raster position, reads and updates the
// two line buffers, builds the 3x3 window and pushes jobs. Depends on rbf_pkg, rbf_ram.
module rbf_front
	import rbf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pixel_t           in_pix,
	input  logic             cfg_valid,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic [QCNT_W-1:0] q_count,
	output logic             push,
	output job_t             push_job
);
	logic [CFG_W-1:0] width_q, height_q;
	logic [EW_W-1:0]  eff_w;
	logic [EH_W-1:0]  eff_h;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             accept, last_col, last_row;

	logic             v_s1;
	pixel_t           pix_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             lastc_s1, lastr_s1;
	pixel_t           win_q [6];
	pixel_t           up_rd, mid_rd;

	always_comb begin
		if (width_q < CFG_W'(2)) begin
			eff_w = EW_W'(2);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			eff_w = EW_W'(MAX_WIDTH);
		end else begin
			eff_w = EW_W'(width_q);
		end
		if (height_q < CFG_W'(2)) begin
			eff_h = EH_W'(2);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			eff_h = EH_W'(MAX_HEIGHT);
		end else begin
			eff_h = EH_W'(height_q);
		end
	end

	// Room is reserved for the item in the second stage before another is taken.
	assign in_ready = (QCNT_W'(q_count) + QCNT_W'(v_s1)) < QCNT_W'(QDEPTH);
	assign accept   = in_valid && in_ready;
	assign last_col = {1'b0, col_q} == (eff_w - EW_W'(1));
	assign last_row = {1'b0, row_q} == (eff_h - EH_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(RST_WIDTH);
			height_q <= CFG_W'(RST_HEIGHT);
			col_q    <= '0;
			row_q    <= '0;
			v_s1     <= 1'b0;
		end else begin
			v_s1 <= accept;
			if (cfg_valid && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT)) begin
				if (cfg_index == REG_FRAME_WIDTH) begin
					width_q <= cfg_data;
				end else begin
					height_q <= cfg_data;
				end
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1   <= in_pix;
			col_s1   <= col_q;
			row_s1   <= row_q;
			lastc_s1 <= last_col;
			lastr_s1 <= last_row;
		end
	end

	rbf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper_line (
		.clk(clk), .we(v_s1), .waddr(col_s1), .wdata(mid_rd),
		.re(accept), .raddr(col_q), .rdata(up_rd)
	);

	rbf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle_line (
		.clk(clk), .we(v_s1), .waddr(col_s1), .wdata(pix_s1),
		.re(accept), .raddr(col_q), .rdata(mid_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (v_s1) begin
			win_q[0] <= win_q[1];
			win_q[1] <= up_rd;
			win_q[2] <= win_q[3];
			win_q[3] <= mid_rd;
			win_q[4] <= win_q[5];
			win_q[5] <= pix_s1;
		end
	end

	// Result order per item: above-left, above (last column), left (last row), own pixel.
	always_comb begin
		push_job.win[0] = {up_rd, win_q[1], win_q[0]};
		push_job.win[1] = {mid_rd, win_q[3], win_q[2]};
		push_job.win[2] = {pix_s1, win_q[5], win_q[4]};
		push_job.col    = col_s1;
		push_job.row    = row_s1;
		push_job.mask[0] = (row_s1 != '0) && (col_s1 != '0);
		push_job.mask[1] = (row_s1 != '0) && lastc_s1;
		push_job.mask[2] = lastr_s1 && (col_s1 != '0);
		push_job.mask[3] = lastr_s1 && lastc_s1;
		push = v_s1 && (push_job.mask != '0);
	end
endmodule

// ===== rtl/core/rbf_queue.sv =====
// Short job queue between the front and back ends of the blur filter.
// Depends on rbf_pkg.
module rbf_queue
	import rbf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  job_t              push_job,
	input  logic              pop,
	output logic              not_empty,
	output job_t              head,
	output logic [QCNT_W-1:0] count
);
	job_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign not_empty = cnt_q != '0;
	assign head      = slot_q[rd_q];
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end
endmodule

// ===== rtl/core/rbf_back.sv =====
// Back end: expands each job into its results, weights the taps and sums them,
// holding the result in an output register. Depends on rbf_pkg.
module rbf_back
	import rbf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_not_empty,
	input  job_t               q_head,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CH_W-1:0]    out_red,
	output logic [CH_W-1:0]    out_green,
	output logic [CH_W-1:0]    out_blue,
	output logic [COORD_W-1:0] out_col,
	output logic [COORD_W-1:0] out_row,
	output logic               frame_done
);
	logic             adv, take, last_of_job, ox, oy, left_edge, top_edge;
	logic [3:0]       done_q, remain, sel;
	window_t          taps;
	logic [COL_W-1:0] px;
	logic [ROW_W-1:0] py;

	logic             v_s1, v_s2, v_s3;
	window_t          taps_s1;
	logic [COL_W-1:0] px_s1, px_s2;
	logic [ROW_W-1:0] py_s1, py_s2;
	logic             fd_s1, fd_s2;
	logic [2:0][2:0][2:0][TAP_W-1:0] tv_s2;
	logic [SUM_W-1:0] sum [3];

	assign adv  = !v_s3 || out_ready;
	assign take = adv && q_not_empty;

	always_comb begin
		remain = q_head.mask & ~done_q;
		sel    = remain & (~remain + 4'd1);
		last_of_job = (remain & ~sel) == '0;
		q_pop  = take && last_of_job;
		ox     = sel[1] || sel[3];
		oy     = sel[2] || sel[3];
		left_edge = !ox && (q_head.col == COL_W'(1));
		top_edge  = !oy && (q_head.row == ROW_W'(1));
		px = ox ? q_head.col : q_head.col - COL_W'(1);
		py = oy ? q_head.row : q_head.row - ROW_W'(1);
		// Taps outside the frame or the window are zeroed, which drops their weight.
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				taps[i][j] = '0;
				if ((i + int'(oy)) <= 2 && (j + int'(ox)) <= 2 &&
					!(left_edge && j == 0) && !(top_edge && i == 0)) begin
					taps[i][j] = q_head.win[i + int'(oy)][j + int'(ox)];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
		end else if (adv) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (take) begin
				done_q <= last_of_job ? '0 : (done_q | sel);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			taps_s1 <= taps;
			px_s1   <= px;
			py_s1   <= py;
			fd_s1   <= sel[3];
			for (int ch = 0; ch < 3; ch++) begin
				for (int i = 0; i < 3; i++) begin
					for (int j = 0; j < 3; j++) begin
						tv_s2[ch][i][j] <= tap_div(taps_s1[i][j][PIX_W-1-CH_W*ch -: CH_W],
							kmul_at(i, j));
					end
				end
			end
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			fd_s2 <= fd_s1;
			out_red    <= CH_W'(sum[0]);
			out_green  <= CH_W'(sum[1]);
			out_blue   <= CH_W'(sum[2]);
			out_col    <= COORD_W'(px_s2);
			out_row    <= COORD_W'(py_s2);
			frame_done <= fd_s2;
		end
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			sum[ch] = '0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					sum[ch] = sum[ch] + SUM_W'(tv_s2[ch][i][j]);
				end
			end
		end
	end

	assign out_valid = v_s3;
endmodule

// ===== rtl/core/rgb_3x3_blur_filter_top.sv =====
// Top level of the 3x3 RGB blur filter: front end, job queue and back end.
// Depends on rbf_pkg, the three channel interfaces, rbf_front, rbf_queue, rbf_back.
//
//   Port     Direction  Carries
//   pix_in   sink       one raster-order RGB888 pixel per item
//   pix_out  source     filtered pixel, its column and row, frame_done
//   cfg      sink       register index and 13-bit data (0 width, 1 height)
//
// A pixel is taken every cycle while the job queue has room; a result taken from the
// queue head passes the tap, weighted-tap and output registers, one result per cycle
// while the output is not stalled. At the end of a row or in the last row one pixel
// releases up to four results, and the back end's single result per cycle sets the pace.
// Reset clears position and control; line buffers are not cleared.
// A stalled output holds the back end; the front stalls only when the queue fills.
module rgb_3x3_blur_filter_top
	import rbf_pkg::*;
(
	input logic           clk,
	input logic           arst_n,
	rbf_pix_in_if.sink    pix_in,
	rbf_pix_out_if.source pix_out,
	rbf_cfg_if.sink       cfg
);
	logic              push, pop, not_empty;
	job_t              push_job, head;
	logic [QCNT_W-1:0] count;

	assign cfg.ready = 1'b1;

	rbf_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(pix_in.valid), .in_ready(pix_in.ready),
		.in_pix({pix_in.in_red, pix_in.in_green, pix_in.in_blue}),
		.cfg_valid(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
		.q_count(count), .push(push), .push_job(push_job)
	);

	rbf_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_job(push_job), .pop(pop),
		.not_empty(not_empty), .head(head), .count(count)
	);

	rbf_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_not_empty(not_empty), .q_head(head), .q_pop(pop),
		.out_valid(pix_out.valid), .out_ready(pix_out.ready),
		.out_red(pix_out.out_red), .out_green(pix_out.out_green),
		.out_blue(pix_out.out_blue), .out_col(pix_out.out_col),
		.out_row(pix_out.out_row), .frame_done(pix_out.frame_done)
	);
endmodule
